// ===== design/ttv_pkg.sv =====
// ----------------------------------------------------------------------------
// ttv_pkg
// Types and constants for the triangle tangent block.
// ----------------------------------------------------------------------------
package ttv_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_in;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic               degenerate;
    } t_out;

    // controller commands to datapath
    typedef struct packed {
        logic hold0;     // capture corner 0
        logic hold1;     // capture corner 1
        logic load;      // capture corner 2, form deltas
        logic mul_a;     // multiply step 1
        logic mul_b;     // multiply step 2
        logic sub;       // form det and numerators
        logic div_init;  // start divide on lane
        logic div_step;  // one quotient bit
        logic div_done;  // store lane result
        logic [1:0] lane;
        logic emit;      // move results to output register
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic out_busy;
    } t_sts;

    localparam int DIV_BITS = 67;

endpackage

// ===== design/triangle_tangent_vector.sv =====
// The three lanes share one bit-serial divider, so the block takes no new corner
// until the current triangle's tangent has been emitted.
// Degenerate triangles skip the divide.
// Reset: synchronous active-low, clears corner count and output valid.
// ----------------------------------------------------------------------------
// triangle_tangent_vector
// Per-triangle tangent from positions and texture coordinates.
// ----------------------------------------------------------------------------
module triangle_tangent_vector
    import ttv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int STEPS = DIV_BITS + FRAC_BITS;

    t_cmd cmd;
    t_sts sts;

    ttv_ctrl #(.STEPS(STEPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sts(sts), .o_cmd(cmd)
    );

    ttv_dp #(.FRAC_BITS(FRAC_BITS), .STEPS(STEPS)) u_dp (
        .i_clk, .i_rst_n, .i_data, .i_cmd(cmd), .i_out_stall(i_stall),
        .o_sts(sts), .o_valid, .o_data
    );

endmodule

// ===== design/ttv_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttv_ctrl
// Corner counting and sequencing of the multiply and divide steps.
// ----------------------------------------------------------------------------
module ttv_ctrl
    import ttv_pkg::*;
#(
    parameter int STEPS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_C0   = 7'b0000001,
        S_C1   = 7'b0000010,
        S_C2   = 7'b0000100,
        S_MULA = 7'b0001000,
        S_MULB = 7'b0010000,
        S_SUB  = 7'b0100000,
        S_DIV  = 7'b1000000
    } t_state;

    localparam int CW = $clog2(STEPS + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_lane, n_lane;
    logic          acc;

    assign o_stall = !(r_state == S_C0 || r_state == S_C1 || r_state == S_C2);
    assign acc     = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lane  = r_lane;
        o_cmd   = '0;
        o_cmd.lane = r_lane;
        unique case (r_state)
            S_C0: begin
                o_cmd.hold0 = acc;
                if (acc) n_state = S_C1;
            end
            S_C1: begin
                o_cmd.hold1 = acc;
                if (acc) n_state = S_C2;
            end
            S_C2: begin
                o_cmd.load = acc;
                if (acc) n_state = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state = S_DIV;
                n_cnt   = '0;
                n_lane  = 2'd0;
            end
            S_DIV: begin
                if (i_sts.det_zero || r_lane == 2'd3) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.emit = 1'b1;
                        n_state = S_C0;
                    end
                end else if (r_cnt == '0) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = CW'(1);
                end else if (r_cnt == CW'(STEPS + 1 - 1) + CW'(1)) begin
                    o_cmd.div_done = 1'b1;
                    n_cnt  = '0;
                    n_lane = r_lane + 2'd1;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            default: n_state = S_C0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_C0;
            r_cnt   <= '0;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lane  <= n_lane;
        end
    end

endmodule

// ===== design/ttv_dp.sv =====
// ----------------------------------------------------------------------------
// ttv_dp
// Corner store, deltas, cross products and restoring divider.
// ----------------------------------------------------------------------------
module ttv_dp
    import ttv_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int STEPS     = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_data,
    input  t_cmd i_cmd,
    input  logic i_out_stall,
    output t_sts o_sts,
    output logic o_valid,
    output t_out o_data
);

    // numerator magnitude < 2^67, shifted: < 2^(67+FRAC_BITS)
    localparam int NW = DIV_BITS + FRAC_BITS;

    logic signed [31:0] r_p0 [3];
    logic signed [31:0] r_p1 [3];
    logic signed [31:0] r_t0 [2];
    logic signed [31:0] r_t1 [2];
    logic signed [32:0] r_dp1 [3];
    logic signed [32:0] r_dp2 [3];
    logic signed [32:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [65:0] r_pa [4];
    logic signed [65:0] r_pb [4];
    logic signed [66:0] r_num [3];
    logic signed [66:0] r_det;
    logic [NW-1:0]      r_n;
    logic [DIV_BITS:0]  r_r;
    logic [STEPS-1:0]   r_q;
    logic [DIV_BITS-1:0] det_mag;
    logic               r_neg;
    logic signed [31:0] r_res [3];
    logic               r_ovalid;
    t_out               r_out;
    logic [DIV_BITS:0]  rem_sh, rem_sub;
    logic signed [66:0] cur_num;
    logic [31:0]        lim, mag;
    logic signed [31:0] sat;

    assign det_mag = r_det[66] ? DIV_BITS'(-r_det) : DIV_BITS'(r_det);
    assign cur_num = r_num[i_cmd.lane];
    assign rem_sh  = {r_r[DIV_BITS-1:0], r_n[NW-1]};
    assign rem_sub = rem_sh - {1'b0, det_mag};

    always_comb begin
        lim  = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag  = (|r_q[STEPS-1:32] || r_q[31:0] > lim) ? lim : r_q[31:0];
        sat  = r_neg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold0) begin
            r_p0[0] <= i_data.pos_x; r_p0[1] <= i_data.pos_y; r_p0[2] <= i_data.pos_z;
            r_t0[0] <= i_data.tex_u; r_t0[1] <= i_data.tex_v;
        end
        if (i_cmd.hold1) begin
            r_p1[0] <= i_data.pos_x; r_p1[1] <= i_data.pos_y; r_p1[2] <= i_data.pos_z;
            r_t1[0] <= i_data.tex_u; r_t1[1] <= i_data.tex_v;
        end
        if (i_cmd.load) begin
            r_dp1[0] <= 33'(r_p1[0]) - 33'(r_p0[0]);
            r_dp1[1] <= 33'(r_p1[1]) - 33'(r_p0[1]);
            r_dp1[2] <= 33'(r_p1[2]) - 33'(r_p0[2]);
            r_dp2[0] <= 33'(i_data.pos_x) - 33'(r_p0[0]);
            r_dp2[1] <= 33'(i_data.pos_y) - 33'(r_p0[1]);
            r_dp2[2] <= 33'(i_data.pos_z) - 33'(r_p0[2]);
            r_du1 <= 33'(r_t1[0]) - 33'(r_t0[0]);
            r_dv1 <= 33'(r_t1[1]) - 33'(r_t0[1]);
            r_du2 <= 33'(i_data.tex_u) - 33'(r_t0[0]);
            r_dv2 <= 33'(i_data.tex_v) - 33'(r_t0[1]);
        end
        // 33x33 products, four per step
        if (i_cmd.mul_a) begin
            r_pa[0] <= r_du1 * r_dv2;     r_pb[0] <= r_dv1 * r_du2;
            r_pa[1] <= r_dp1[0] * r_dv2;  r_pb[1] <= r_dp2[0] * r_dv1;
        end
        if (i_cmd.mul_b) begin
            r_pa[2] <= r_dp1[1] * r_dv2;  r_pb[2] <= r_dp2[1] * r_dv1;
            r_pa[3] <= r_dp1[2] * r_dv2;  r_pb[3] <= r_dp2[2] * r_dv1;
        end
        if (i_cmd.sub) begin
            r_det    <= 67'(r_pa[0]) - 67'(r_pb[0]);
            r_num[0] <= 67'(r_pa[1]) - 67'(r_pb[1]);
            r_num[1] <= 67'(r_pa[2]) - 67'(r_pb[2]);
            r_num[2] <= 67'(r_pa[3]) - 67'(r_pb[3]);
        end
        if (i_cmd.div_init) begin
            r_n   <= {(cur_num[66] ? DIV_BITS'(-cur_num) : DIV_BITS'(cur_num)),
                      FRAC_BITS'(0)};
            r_r   <= '0;
            r_q   <= '0;
            r_neg <= cur_num[66] ^ r_det[66];
        end
        if (i_cmd.div_step) begin
            r_n <= {r_n[NW-2:0], 1'b0};
            if (!rem_sub[DIV_BITS]) begin
                r_r <= rem_sub;
                r_q <= {r_q[STEPS-2:0], 1'b1};
            end else begin
                r_r <= rem_sh;
                r_q <= {r_q[STEPS-2:0], 1'b0};
            end
        end
        if (i_cmd.div_done) r_res[i_cmd.lane] <= sat;
        if (i_cmd.emit) begin
            r_out.degenerate <= (r_det == '0);
            r_out.tangent_x  <= (r_det == '0) ? '0 : r_res[0];
            r_out.tangent_y  <= (r_det == '0) ? '0 : r_res[1];
            r_out.tangent_z  <= (r_det == '0) ? '0 : r_res[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.det_zero = (r_det == '0);
    assign o_sts.out_busy = r_ovalid && i_out_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// ===== design/ttv_check.sv =====
// ----------------------------------------------------------------------------
// ttv_check
// Port-level checks for the triangle tangent block.
// ----------------------------------------------------------------------------
module ttv_check
    import ttv_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("out hold");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.tangent_x == '0 &&
        o_data.tangent_y == '0 && o_data.tangent_z == '0) else $error("degenerate");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall) else $error("input closed after result");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !$isunknown(o_stall)) else $error("stall unknown");

endmodule

bind triangle_tangent_vector ttv_check u_ttv_check (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_data
);

// ===== sim/tb_triangle_tangent_vector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_vector
// Streams vertices into the tangent block and checks every tangent against
// a bit-exact predictor: a directed table of corner cases, then random
// triangles, first under random idle patterns on both sides of the handshake, then with none.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_vector;
    import ttv_pkg::*;

    localparam int FRAC = 16;
    localparam int TRI_LAT = 3 * (67 + FRAC + 2) + 10;
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM = 1428;
    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    triangle_tangent_vector #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned corners_held;
    t_in         corner_store [2];
    t_out        tangent_queue [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned errors = 0;
    int unsigned table_errors;
    longint      cycle_count = 0;

    // num * 2^FRAC / det, truncated toward zero, saturated to 32 bits
    function automatic logic signed [31:0] tangent_component(
        logic signed [127:0] num, logic signed [127:0] det);
        logic signed [127:0] q;
        logic signed [127:0] n;
        n = num <<< FRAC;
        q = n / det;
        if (q > 128'sd2147483647)
            return 32'h7fffffff;
        else if (q < -128'sd2147483648)
            return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic void predict_tangent(t_in v);
        logic signed [127:0] dp1 [3];
        logic signed [127:0] dp2 [3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        t_out r;
        if (corners_held < 2) begin
            corner_store[corners_held] = v;
            corners_held++;
            return;
        end
        corners_held = 0;
        dp1[0] = 128'(corner_store[1].pos_x) - 128'(corner_store[0].pos_x);
        dp1[1] = 128'(corner_store[1].pos_y) - 128'(corner_store[0].pos_y);
        dp1[2] = 128'(corner_store[1].pos_z) - 128'(corner_store[0].pos_z);
        dp2[0] = 128'(v.pos_x) - 128'(corner_store[0].pos_x);
        dp2[1] = 128'(v.pos_y) - 128'(corner_store[0].pos_y);
        dp2[2] = 128'(v.pos_z) - 128'(corner_store[0].pos_z);
        du1 = 128'(corner_store[1].tex_u) - 128'(corner_store[0].tex_u);
        dv1 = 128'(corner_store[1].tex_v) - 128'(corner_store[0].tex_v);
        du2 = 128'(v.tex_u) - 128'(corner_store[0].tex_u);
        dv2 = 128'(v.tex_v) - 128'(corner_store[0].tex_v);
        det = du1 * dv2 - dv1 * du2;
        r = '0;
        if (det == 0) begin
            r.degenerate = 1'b1;
        end else begin
            r.tangent_x = tangent_component(dp1[0] * dv2 - dp2[0] * dv1, det);
            r.tangent_y = tangent_component(dp1[1] * dv2 - dp2[1] * dv1, det);
            r.tangent_z = tangent_component(dp1[2] * dv2 - dp2[2] * dv1, det);
        end
        tangent_queue = {tangent_queue, r};
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return 32'(int'($urandom_range(0, 8)) - 4) <<< FRAC;
            3: return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in rand_corner();
        t_in v;
        v.pos_x = rand_word();
        v.pos_y = rand_word();
        v.pos_z = rand_word();
        v.tex_u = rand_word();
        v.tex_v = rand_word();
        return v;
    endfunction

    task automatic send_corner(t_in v);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_tangent(v);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (tangent_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected tangent %h", o_data);
            end else begin
                t_out e;
                e = tangent_queue.pop_front();
                if (o_data.tangent_x !== e.tangent_x || o_data.tangent_y !== e.tangent_y ||
                    o_data.tangent_z !== e.tangent_z ||
                    o_data.degenerate !== e.degenerate) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %h %h %h %b got %h %h %h %b",
                                 e.tangent_x, e.tangent_y, e.tangent_z, e.degenerate,
                                 o_data.tangent_x, o_data.tangent_y, o_data.tangent_z,
                                 o_data.degenerate);
                end
            end
        end
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // directed table: corners in groups of three
    t_in directed [N_DIRECTED];
    // typed-in tangents for the at-a-glance rows (one per triangle)
    t_out known [N_DIRECTED / 3];
    logic known_set [N_DIRECTED / 3];

    function automatic t_in mk(logic [31:0] px, py, pz, tu, tv);
        t_in v;
        v.pos_x = px; v.pos_y = py; v.pos_z = pz; v.tex_u = tu; v.tex_v = tv;
        return v;
    endfunction

    initial begin
        int k;
        int tri_idx;
        int waited;
        t_out unit_t;
        corners_held = 0;
        send_idle_pct = 12;
        recv_stall_pct = 87;
        table_errors = 0;
        for (k = 0; k < N_DIRECTED / 3; k++) known_set[k] = 1'b0;
        // unit triangle: T = (1,0,0)
        directed[0] = mk(0, 0, 0, 0, 0);
        directed[1] = mk(32'h10000, 0, 0, 32'h10000, 0);
        directed[2] = mk(0, 32'h10000, 0, 0, 32'h10000);
        unit_t = '0; unit_t.tangent_x = 32'h10000;
        known[0] = unit_t; known_set[0] = 1'b1;
        // zero determinant
        directed[3] = mk(1, 2, 3, 32'h10000, 32'h10000);
        directed[4] = mk(4, 5, 6, 32'h10000, 32'h10000);
        directed[5] = mk(7, 8, 9, 32'h10000, 32'h10000);
        known[1] = '0; known[1].degenerate = 1'b1; known_set[1] = 1'b1;
        // positive overflow (x, y) and negative overflow (z)
        directed[6] = mk(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0);
        directed[7] = mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1, 0);
        directed[8] = mk(0, 0, 0, 0, 1);
        // min-max extremes of texcoords
        directed[9] = mk(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'h80000000);
        directed[10] = mk(32'h80000000, 32'hffffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h80000000);
        directed[11] = mk(32'hffffffff, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff);
        // truncation toward zero, negative quotients
        directed[12] = mk(0, 0, 0, 0, 0);
        directed[13] = mk(1, 32'hffffffff, 2, 3, 0);
        directed[14] = mk(0, 0, 0, 0, 32'hfffffffd);
        directed[15] = mk(5, 5, 5, 0, 0);
        directed[16] = mk(10, 0, 32'hfffffff0, 7, 3);
        directed[17] = mk(0, 12, 1, 32'hfffffffe, 11);
        // all ones / alternating bits
        directed[18] = mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        directed[19] = mk(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
        directed[20] = mk(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'h0);
        directed[21] = mk(0, 0, 0, 0, 0);
        directed[22] = mk(0, 0, 0, 32'h7fffffff, 32'h7fffffff);
        directed[23] = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            send_corner(directed[k]);
            tri_idx = k / 3;
            if (k % 3 == 2 && known_set[tri_idx] &&
                tangent_queue[tangent_queue.size() - 1] != known[tri_idx]) begin
                table_errors++;
                if (table_errors <= 10)
                    $display("directed triangle %0d exp %h got %h", tri_idx,
                             known[tri_idx], tangent_queue[tangent_queue.size() - 1]);
            end
        end

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                send_idle_pct = 87;
                recv_stall_pct = 12;
            end else if (k == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            send_corner(rand_corner());
        end
        i_valid <= 1'b0;

        waited = 0;
        while (tangent_queue.size() != 0 && waited < 50 * TRI_LAT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TRI_LAT) @(posedge i_clk);
        if (errors == 0 && table_errors == 0 && tangent_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== triangle_tangent_vector.f =====
design/ttv_pkg.sv
design/ttv_ctrl.sv
design/ttv_dp.sv
design/triangle_tangent_vector.sv
design/ttv_check.sv
sim/tb_triangle_tangent_vector.sv
